>>> src/rpa_pkg.sv
package rpa_pkg;

    localparam int PAGE_W     = 15;
    localparam int NUM_PAGES  = 2 ** PAGE_W;
    localparam int DEPTH_W    = PAGE_W + 1;
    localparam int COUNT_BITS = 8;
    localparam int REFCNT_W   = 8;

    typedef logic [PAGE_W-1:0]     page_t;
    typedef logic [DEPTH_W-1:0]    depth_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX   = '1;
    localparam depth_t DEPTH_FULL  = DEPTH_W'(NUM_PAGES);
    localparam page_t  LAST_PAGE   = '1;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_ADDREF = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_RANGE = 3'd2,
        ST_ZERO  = 3'd3,
        ST_SAT   = 3'd4,
        ST_FULL  = 3'd5
    } status_t;

    typedef struct packed {
        action_t action;
        page_t   page_index;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        page_t               result_page;
        logic [REFCNT_W-1:0] ref_count;
        logic                released;
    } out_item_t;

endpackage

>>> src/refcounted_page_allocator.sv
// Reference-counted page frame allocator. Per-page counts live in a
// 32768 x 8 synchronous memory and freed pages on a 32768-deep LIFO stack
// in a second memory; pages never handed out yet are given from a
// descending frontier, highest first, once the stack is empty. After reset
// a clearing pass zeroes the count memory, one entry a cycle, over all 32768
// entries with s_ready low (first_page writes are taken throughout). Each
// item is then accepted in the idle state, which issues the count and stack
// reads, and finished in the execute state, which uses the registered read
// data and writes the memories back as the action needs. The result sits
// in an output register, so the next item is accepted while it waits; the
// execute cycle stalls only while an earlier result is still untaken.
module refcounted_page_allocator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpa_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  rpa_pkg::page_t     cfg_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    rpa_pkg::page_t      clr_addr_reg, clr_addr_next;
    rpa_pkg::in_item_t   item_reg, item_next;
    rpa_pkg::depth_t     depth_reg, depth_next;
    rpa_pkg::depth_t     frontier_reg, frontier_next;
    rpa_pkg::page_t      first_page_reg, first_page_next;
    logic                m_valid_reg, m_valid_next;
    rpa_pkg::out_item_t  m_item_reg, m_item_next;

    logic                cnt_we;
    rpa_pkg::page_t      cnt_waddr;
    rpa_pkg::count_t     cnt_wdata;
    rpa_pkg::count_t     cnt_rd;
    logic                stk_we;
    rpa_pkg::page_t      stk_waddr;
    rpa_pkg::page_t      stk_rd;
    logic                rd_en;
    rpa_pkg::depth_t     depth_m1;
    rpa_pkg::depth_t     frontier_m1;
    rpa_pkg::count_t     cnt_dec;
    rpa_pkg::count_t     cnt_inc;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign rd_en       = s_valid && s_ready;
    assign depth_m1    = depth_reg - rpa_pkg::DEPTH_W'(1);
    assign frontier_m1 = frontier_reg - rpa_pkg::DEPTH_W'(1);
    assign cnt_dec     = cnt_rd - rpa_pkg::COUNT_BITS'(1);
    assign cnt_inc     = cnt_rd + rpa_pkg::COUNT_BITS'(1);
    assign stk_waddr   = depth_reg[rpa_pkg::PAGE_W-1:0];

    rpa_ram #(
        .DEPTH (rpa_pkg::NUM_PAGES),
        .WIDTH (rpa_pkg::COUNT_BITS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (rd_en),
        .rd_addr (s_item.page_index),
        .rd_data (cnt_rd)
    );

    rpa_ram #(
        .DEPTH (rpa_pkg::NUM_PAGES),
        .WIDTH (rpa_pkg::PAGE_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (item_reg.page_index),
        .rd_en   (rd_en),
        .rd_addr (depth_m1[rpa_pkg::PAGE_W-1:0]),
        .rd_data (stk_rd)
    );

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        item_next       = item_reg;
        depth_next      = depth_reg;
        frontier_next   = frontier_reg;
        first_page_next = first_page_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = item_reg.page_index;
        cnt_wdata       = '0;
        stk_we          = 1'b0;

        if (cfg_valid && cfg_ready) begin
            first_page_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + rpa_pkg::PAGE_W'(1);
                if (clr_addr_reg == rpa_pkg::LAST_PAGE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (rd_en) begin
                    item_next  = s_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next               = S_IDLE;
                    m_valid_next             = 1'b1;
                    m_item_next.status       = rpa_pkg::ST_OK;
                    m_item_next.result_page  = item_reg.page_index;
                    m_item_next.ref_count    = rpa_pkg::REFCNT_W'(cnt_rd);
                    m_item_next.released     = 1'b0;
                    unique case (item_reg.action)
                        rpa_pkg::ACT_ALLOC: begin
                            m_item_next.ref_count = rpa_pkg::REFCNT_W'(1);
                            priority if (depth_reg != '0) begin
                                depth_next              = depth_m1;
                                cnt_we                  = 1'b1;
                                cnt_waddr               = stk_rd;
                                cnt_wdata               = rpa_pkg::COUNT_BITS'(1);
                                m_item_next.result_page = stk_rd;
                            end else if (frontier_reg > {1'b0, first_page_reg}) begin
                                frontier_next           = frontier_m1;
                                cnt_we                  = 1'b1;
                                cnt_waddr               = frontier_m1[rpa_pkg::PAGE_W-1:0];
                                cnt_wdata               = rpa_pkg::COUNT_BITS'(1);
                                m_item_next.result_page = frontier_m1[rpa_pkg::PAGE_W-1:0];
                            end else begin
                                m_item_next.status    = rpa_pkg::ST_OOM;
                                m_item_next.ref_count = '0;
                            end
                        end
                        rpa_pkg::ACT_FREE: begin
                            priority if (item_reg.page_index < first_page_reg) begin
                                m_item_next.status = rpa_pkg::ST_RANGE;
                            end else if (cnt_rd == '0) begin
                                m_item_next.status = rpa_pkg::ST_ZERO;
                            end else begin
                                cnt_we                = 1'b1;
                                cnt_wdata             = cnt_dec;
                                m_item_next.ref_count = rpa_pkg::REFCNT_W'(cnt_dec);
                                // last reference gone: push unless the stack is full
                                if (cnt_dec == '0) begin
                                    if (depth_reg == rpa_pkg::DEPTH_FULL) begin
                                        m_item_next.status = rpa_pkg::ST_FULL;
                                    end else begin
                                        stk_we               = 1'b1;
                                        depth_next           = depth_reg + rpa_pkg::DEPTH_W'(1);
                                        m_item_next.released = 1'b1;
                                    end
                                end
                            end
                        end
                        rpa_pkg::ACT_ADDREF: begin
                            if (cnt_rd == rpa_pkg::COUNT_MAX) begin
                                m_item_next.status = rpa_pkg::ST_SAT;
                            end else begin
                                cnt_we                = 1'b1;
                                cnt_wdata             = cnt_inc;
                                m_item_next.ref_count = rpa_pkg::REFCNT_W'(cnt_inc);
                            end
                        end
                        rpa_pkg::ACT_READ: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            depth_reg      <= '0;
            frontier_reg   <= rpa_pkg::DEPTH_W'(rpa_pkg::NUM_PAGES);
            first_page_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            depth_reg      <= depth_next;
            frontier_reg   <= frontier_next;
            first_page_reg <= first_page_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        m_item_reg <= m_item_next;
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= rpa_pkg::DEPTH_FULL)
        else $error("free stack depth beyond capacity");

    a_frontier_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frontier_reg <= rpa_pkg::DEPTH_W'(rpa_pkg::NUM_PAGES))
        else $error("frontier beyond page range");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !m_valid_reg && !stk_we)
        else $error("result or push during clearing pass");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

endmodule

>>> src/rpa_ram.sv
module rpa_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
